// File: rtl/vn_pkg.sv
// Shared constants and types for the 3-D vector normalizer.
package vn_pkg;

    localparam int COMPONENT_WIDTH      = 32;
    localparam int OUTPUT_FRACTION_BITS = 30;

    // Flags carried down the pipeline beside the data.
    typedef struct packed {
        logic valid;
        logic neg;
    } lane_ctl_t;

endpackage

// File: rtl/vn_sqrt.sv
// Pipelined floor square root, one result bit per stage.
module vn_sqrt #(
    parameter int SUM_WIDTH  = 2 * vn_pkg::COMPONENT_WIDTH + 2,
    parameter int ROOT_WIDTH = vn_pkg::COMPONENT_WIDTH + 1,
    parameter int SIDE_WIDTH = 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  logic                  in_valid,
    input  logic [SUM_WIDTH-1:0]  radicand,
    input  logic [SIDE_WIDTH-1:0] in_side,
    output logic                  out_valid,
    output logic [ROOT_WIDTH-1:0] root,
    output logic [SIDE_WIDTH-1:0] out_side
);

    localparam int RW = 2 * ROOT_WIDTH;

    // Non-restoring-free digit recurrence: remainder, root so far, radicand left.
    logic [RW-1:0]         rem_reg  [ROOT_WIDTH+1];
    logic [ROOT_WIDTH-1:0] root_reg [ROOT_WIDTH+1];
    logic [RW-1:0]         rad_reg  [ROOT_WIDTH+1];
    logic [SIDE_WIDTH-1:0] side_reg [ROOT_WIDTH+1];
    logic                  vld_reg  [ROOT_WIDTH+1];

    always_comb
    begin
        rem_reg[0]  = '0;
        root_reg[0] = '0;
        rad_reg[0]  = RW'(radicand);
        side_reg[0] = in_side;
        vld_reg[0]  = in_valid;
    end

    genvar s;
    generate
        for (s = 0; s < ROOT_WIDTH; s++)
        begin : g_stage
            logic [RW+1:0] rem_shift;
            logic [RW+1:0] trial;
            assign rem_shift = {rem_reg[s], rad_reg[s][RW-1 -: 2]};
            assign trial     = (RW+2)'({root_reg[s], 2'b01});

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[s+1] <= 1'b0;
                end
                else if (advance)
                begin
                    vld_reg[s+1] <= vld_reg[s];
                end
            end

            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    rad_reg[s+1]  <= {rad_reg[s][RW-3:0], 2'b00};
                    side_reg[s+1] <= side_reg[s];
                    if (rem_shift >= trial)
                    begin
                        rem_reg[s+1]  <= RW'(rem_shift - trial);
                        root_reg[s+1] <= {root_reg[s][ROOT_WIDTH-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg[s+1]  <= RW'(rem_shift);
                        root_reg[s+1] <= {root_reg[s][ROOT_WIDTH-2:0], 1'b0};
                    end
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[ROOT_WIDTH];
    assign root      = root_reg[ROOT_WIDTH];
    assign out_side  = side_reg[ROOT_WIDTH];

endmodule

// File: rtl/vn_div.sv
// Pipelined restoring divider: (mag << FB) / den, clamped to 2^FB, one bit per stage.
module vn_div #(
    parameter int MAG_WIDTH  = vn_pkg::COMPONENT_WIDTH,
    parameter int DEN_WIDTH  = vn_pkg::COMPONENT_WIDTH + 1,
    parameter int FB         = vn_pkg::OUTPUT_FRACTION_BITS,
    parameter int SIDE_WIDTH = 1
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  logic                  in_valid,
    input  logic [MAG_WIDTH-1:0]  mag,
    input  logic [DEN_WIDTH-1:0]  den,
    input  logic [SIDE_WIDTH-1:0] in_side,
    output logic                  out_valid,
    output logic [FB:0]           quot,
    output logic [SIDE_WIDTH-1:0] out_side
);

    // Quotient window is QW bits; a numerator at or above den << QW would
    // need more, so it raises the overflow flag and the result clamps.
    localparam int QW = FB + 2;
    localparam int NW = MAG_WIDTH + FB;

    logic [DEN_WIDTH:0]    rem_reg  [QW+1];
    logic [NW-1:0]         num_reg  [QW+1];
    logic [DEN_WIDTH-1:0]  den_reg  [QW+1];
    logic [QW-1:0]         q_reg    [QW+1];
    logic                  ovf_reg  [QW+1];
    logic [SIDE_WIDTH-1:0] side_reg [QW+1];
    logic                  vld_reg  [QW+1];

    logic [NW-1:0] num_full;
    assign num_full = {mag, FB'(0)};

    // Remainder starts from the numerator bits above the quotient window;
    // stage s then brings down numerator bit QW-1-s.
    always_comb
    begin
        rem_reg[0]  = (DEN_WIDTH+1)'(num_full >> QW);
        num_reg[0]  = num_full;
        den_reg[0]  = den;
        q_reg[0]    = '0;
        ovf_reg[0]  = 1'b0;
        side_reg[0] = in_side;
        vld_reg[0]  = in_valid;
    end

    // Overflow when the numerator reaches den << QW.
    logic [NW+DEN_WIDTH:0] pre_ovf_chk;
    assign pre_ovf_chk = (NW+DEN_WIDTH+1)'(num_full)
                       - ((NW+DEN_WIDTH+1)'(den) << QW);
    logic pre_ovf;
    assign pre_ovf = !pre_ovf_chk[NW+DEN_WIDTH];

    genvar s;
    generate
        for (s = 0; s < QW; s++)
        begin : g_stage
            logic [DEN_WIDTH+1:0] rem_shift;
            logic                 take;
            assign rem_shift = {rem_reg[s], num_reg[s][QW-1-s]};
            assign take      = rem_shift >= (DEN_WIDTH+2)'(den_reg[s]);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[s+1] <= 1'b0;
                end
                else if (advance)
                begin
                    vld_reg[s+1] <= vld_reg[s];
                end
            end

            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    num_reg[s+1]  <= num_reg[s];
                    den_reg[s+1]  <= den_reg[s];
                    side_reg[s+1] <= side_reg[s];
                    ovf_reg[s+1]  <= (s == 0) ? pre_ovf : ovf_reg[s];
                    rem_reg[s+1]  <= take ? (DEN_WIDTH+1)'(rem_shift - (DEN_WIDTH+2)'(den_reg[s]))
                                          : (DEN_WIDTH+1)'(rem_shift);
                    q_reg[s+1]    <= {q_reg[s][QW-2:0], take};
                end
            end
        end
    endgenerate

    logic [QW-1:0] one_q;
    assign one_q = QW'(1) << FB;

    assign out_valid = vld_reg[QW];
    assign out_side  = side_reg[QW];
    assign quot = (ovf_reg[QW] || (q_reg[QW] > one_q)) ? (FB+1)'(one_q)
                                                       : q_reg[QW][FB:0];

endmodule

// File: rtl/vector3_normalize.sv
// Top level of the 3-D vector normalizer.
//
//  channel   | dir | tdata (low bit up)                 | tuser
//  s_axis    | in  | in_x, in_y, in_z                   | -
//  m_axis    | out | unit_x, unit_y, unit_z             | zero_length
//
// One vector enters per cycle while m_axis is not stalled. The pipe is a
// square stage, an add stage, the bit-per-stage root pipe, the bit-per-stage
// divider pipe and the output register. Reset clears only valid bits. A stall
// on m_axis freezes the whole pipe; s_axis_tready is high whenever the output
// register is empty or is being taken.
module vector3_normalize #(
    parameter int COMPONENT_WIDTH      = vn_pkg::COMPONENT_WIDTH,
    parameter int OUTPUT_FRACTION_BITS = vn_pkg::OUTPUT_FRACTION_BITS
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // in_x, in_y, in_z, zero padding
    input  logic [((3*COMPONENT_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // unit_x, unit_y, unit_z, zero padding
    output logic [((3*(OUTPUT_FRACTION_BITS+2)+7)/8)*8-1:0] m_axis_tdata,
    // zero_length
    output logic [0:0] m_axis_tuser
);

    localparam int CW  = COMPONENT_WIDTH;
    localparam int OFB = OUTPUT_FRACTION_BITS;
    localparam int OW  = OFB + 2;
    localparam int SW  = 2 * CW + 2;
    localparam int RTW = CW + 1;
    localparam int ODW = ((3*OW+7)/8)*8;
    // side info carried through the root: mags and signs of the three lanes
    localparam int SIDE = 3 * CW + 3;

    logic advance;
    assign advance = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = advance;

    // stage 1: magnitudes and squares
    logic [CW-1:0]   mag_in [3];
    logic [2:0]      neg_in;
    logic [2*CW-1:0] sq_reg [3];
    logic [CW-1:0]   mag1_reg [3];
    logic [2:0]      neg1_reg;
    logic            vld1_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            neg_in[k] = s_axis_tdata[k*CW + CW-1];
            mag_in[k] = neg_in[k] ? CW'(-s_axis_tdata[k*CW +: CW])
                                  : s_axis_tdata[k*CW +: CW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < 3; k++)
            begin
                sq_reg[k]   <= (2*CW)'(mag_in[k]) * (2*CW)'(mag_in[k]);
                mag1_reg[k] <= mag_in[k];
            end
            neg1_reg <= neg_in;
        end
    end

    // stage 2: sum of squares
    logic [SW-1:0] sum_reg;
    logic [SIDE-1:0] side2_reg;
    logic vld2_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sum_reg   <= SW'(sq_reg[0]) + SW'(sq_reg[1]) + SW'(sq_reg[2]);
            side2_reg <= {neg1_reg, mag1_reg[2], mag1_reg[1], mag1_reg[0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
        end
        else if (advance)
        begin
            vld1_reg <= s_axis_tvalid;
            vld2_reg <= vld1_reg;
        end
    end

    // root
    logic            rt_valid;
    logic [RTW-1:0]  len;
    logic [SIDE-1:0] rt_side;
    logic [SIDE-1:0] rt_side_in;
    assign rt_side_in = side2_reg;

    vn_sqrt #(
        .SUM_WIDTH  (SW),
        .ROOT_WIDTH (RTW),
        .SIDE_WIDTH (SIDE)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (vld2_reg),
        .radicand  (sum_reg),
        .in_side   (rt_side_in),
        .out_valid (rt_valid),
        .root      (len),
        .out_side  (rt_side)
    );

    // zero length when root is zero; feed 1 as divisor to keep dividers sane
    logic           zl;
    logic [RTW-1:0] den;
    assign zl  = (len == '0);
    assign den = zl ? RTW'(1) : len;

    logic           dv_valid [3];
    logic [OFB:0]   q        [3];
    logic [1:0]     dv_side  [3];

    genvar k;
    generate
        for (k = 0; k < 3; k++)
        begin : g_lane
            vn_div #(
                .MAG_WIDTH  (CW),
                .DEN_WIDTH  (RTW),
                .FB         (OFB),
                .SIDE_WIDTH (2)
            ) u_div (
                .clk       (clk),
                .rst_n     (rst_n),
                .advance   (advance),
                .in_valid  (rt_valid),
                .mag       (rt_side[k*CW +: CW]),
                .den       (den),
                .in_side   ({zl, rt_side[3*CW + k]}),
                .out_valid (dv_valid[k]),
                .quot      (q[k]),
                .out_side  (dv_side[k])
            );
        end
    endgenerate

    // output register
    logic [ODW-1:0] tdata_next;
    always_comb
    begin
        tdata_next = '0;
        for (int j = 0; j < 3; j++)
        begin
            if (!dv_side[0][1])
            begin
                tdata_next[j*OW +: OW] = dv_side[j][0] ? OW'(-OW'(q[j])) : OW'(q[j]);
            end
        end
    end

    logic [ODW-1:0] tdata_reg;
    logic           zl_reg;
    logic           ovld_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tdata_reg <= tdata_next;
            zl_reg    <= dv_side[0][1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovld_reg <= 1'b0;
        end
        else if (advance)
        begin
            ovld_reg <= dv_valid[0];
        end
    end

    assign m_axis_tvalid = ovld_reg;
    assign m_axis_tdata  = tdata_reg;
    assign m_axis_tuser  = zl_reg;

endmodule

// File: rtl/vn_checker.sv
// Port-level checks for the vector normalizer, bound to the top level.
module vn_checker #(
    parameter int ODW = 96
) (
    input logic           clk,
    input logic           rst_n,
    input logic           m_axis_tvalid,
    input logic           m_axis_tready,
    input logic           s_axis_tready,
    input logic [ODW-1:0] m_axis_tdata,
    input logic [0:0]     m_axis_tuser
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output dropped while stalled");

    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("zero vector gave nonzero data");

endmodule

bind vector3_normalize vn_checker #(.ODW(ODW)) u_vn_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// File: tb/vector3_normalize_tb.sv
// Testbench for the 3-D vector normalizer: directed and random vectors checked against a predictor.
`timescale 1ns / 100ps

module vector3_normalize_tb;

    localparam int CW   = vn_pkg::COMPONENT_WIDTH;
    localparam int OFB  = vn_pkg::OUTPUT_FRACTION_BITS;
    localparam int OW   = OFB + 2;
    localparam int IN_W  = ((3 * CW + 7) / 8) * 8;
    localparam int OUT_W = ((3 * OW + 7) / 8) * 8;
    // Pipe depth from the top-level header: square, add, root, divide, output reg.
    localparam int LATENCY = 2 + (CW + 1) + (OFB + 2) + 1;
    localparam int CYCLE_LIMIT = 400000;

    // One expected normalized vector.
    typedef struct {
        logic [OW-1:0] ux;
        logic [OW-1:0] uy;
        logic [OW-1:0] uz;
        logic          zero_len;
    } unit_vec_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata;   // in_x, in_y, in_z, zero padding
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [OUT_W-1:0] m_axis_tdata;  // unit_x, unit_y, unit_z, zero padding
    logic [0:0] m_axis_tuser;        // zero_length

    unit_vec_t expected_units[$];
    int  error_count;
    int  cycle_count;
    bit  stall_rx;    // when set, the sink ready pattern has no low gaps

    vector3_normalize DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("vector3_normalize: mismatch");
            $finish;
        end
    end

    // No gap just over half the time, else mostly a short one, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 95)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // floor(sqrt(n)) by bit-at-a-time trial; n fits in 2*CW+2 bits.
    function automatic logic [63:0] floor_root(logic [127:0] n);
        logic [63:0]  r;
        logic [63:0]  t;
        logic [127:0] sq;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            t  = r | (64'd1 << b);
            sq = 128'(t) * 128'(t);
            if (sq <= n)
                r = t;
        end
        return r;
    endfunction

    // Exact normalization of one vector, truncating and clamping to one.
    function automatic unit_vec_t normalize_vec(logic [CW-1:0] x, logic [CW-1:0] y,
                                                logic [CW-1:0] z);
        unit_vec_t      res;
        logic [CW-1:0]  comp[3];
        logic [CW:0]    mag[3];
        logic           neg[3];
        logic [127:0]   sum;
        logic [63:0]    len;
        logic [127:0]   q;
        logic [OW-1:0]  lane[3];
        comp[0] = x;
        comp[1] = y;
        comp[2] = z;
        sum = '0;
        for (int k = 0; k < 3; k++)
        begin
            neg[k] = comp[k][CW-1];
            // One extra bit keeps the most negative value exact.
            mag[k] = neg[k] ? ((CW+1)'(0) - {1'b1, comp[k]}) : {1'b0, comp[k]};
            sum += 128'(mag[k]) * 128'(mag[k]);
        end
        if (sum == 0)
        begin
            res.ux = '0;
            res.uy = '0;
            res.uz = '0;
            res.zero_len = 1'b1;
            return res;
        end
        len = floor_root(sum);
        for (int k = 0; k < 3; k++)
        begin
            q = (128'(mag[k]) << OFB) / 128'(len);
            if (q > (128'd1 << OFB))
                q = 128'd1 << OFB;
            lane[k] = neg[k] ? OW'(-q) : OW'(q);
        end
        res.ux = lane[0];
        res.uy = lane[1];
        res.uz = lane[2];
        res.zero_len = 1'b0;
        return res;
    endfunction

    // Send one vector and queue its expected result at acceptance.
    // Valid stays high into the next call when there is no gap.
    task automatic send_vector(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z);
        int gap;
        gap = gap_len();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'({z, y, x});
        do
            @(posedge clk);
        while (!s_axis_tready);
        expected_units.push_back(normalize_vec(x, y, z));
    endtask

    // Random component with a mix of magnitudes so small and large lengths both show up.
    function automatic logic [CW-1:0] rand_comp();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0:       return '0;
            1:       return CW'($signed($urandom_range(0, 16)) - 8);
            2:       return {1'b1, {(CW-1){1'b0}}};
            3:       return {1'b0, {(CW-1){1'b1}}};
            4, 5:    return CW'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return CW'($urandom);
        endcase
    endfunction

    // Drain point: stop sending, then wait until everything sent has come back.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_units.size() != 0)
            @(posedge clk);
    endtask

    // Sink side: random ready, results compared on each accepted transaction.
    always @(posedge clk)
    begin
        unit_vec_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_units.size() == 0)
            begin
                $error("unexpected result transaction");
                error_count++;
            end
            else
            begin
                want = expected_units.pop_front();
                if (m_axis_tdata[OW-1:0] !== want.ux)
                begin
                    $error("unit_x: expected %h, got %h", want.ux, m_axis_tdata[OW-1:0]);
                    error_count++;
                end
                if (m_axis_tdata[2*OW-1:OW] !== want.uy)
                begin
                    $error("unit_y: expected %h, got %h", want.uy, m_axis_tdata[2*OW-1:OW]);
                    error_count++;
                end
                if (m_axis_tdata[3*OW-1:2*OW] !== want.uz)
                begin
                    $error("unit_z: expected %h, got %h", want.uz,
                           m_axis_tdata[3*OW-1:2*OW]);
                    error_count++;
                end
                if (m_axis_tuser[0] !== want.zero_len)
                begin
                    $error("zero_length: expected %b, got %b", want.zero_len,
                           m_axis_tuser[0]);
                    error_count++;
                end
            end
        end
    end

    // Ready pattern: runs of high with random stalls, mostly short, some long.
    initial
    begin
        int n;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = $urandom_range(1, 30);
            m_axis_tready <= 1'b1;
            repeat (n) @(posedge clk);
            n = stall_rx ? 0 : gap_len();
            if (n > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
        end
    end

    task automatic test_extremes();
        logic [CW-1:0] vals[6];
        vals[0] = '0;
        vals[1] = CW'(1);
        vals[2] = '1;
        vals[3] = {1'b1, {(CW-1){1'b0}}};
        vals[4] = {1'b0, {(CW-1){1'b1}}};
        vals[5] = CW'(32'h0001_0000);
        // zero vector, single-axis units, most-negative and full-scale mixes
        send_vector('0, '0, '0);
        send_vector(vals[1], '0, '0);
        send_vector('0, vals[2], '0);
        send_vector('0, '0, vals[3]);
        send_vector(vals[3], vals[3], vals[3]);
        send_vector(vals[4], vals[4], vals[4]);
        send_vector(vals[3], vals[4], vals[1]);
        send_vector(vals[5], vals[5], vals[5]);
        send_vector(vals[2], vals[2], vals[2]);
        send_vector(vals[1], vals[1], vals[1]);
        send_vector(vals[4], '0, '0);
        send_vector('0, vals[3], vals[2]);
        // small magnitudes where the floor root is far below the true length, then a large mix
        send_vector(CW'(1), CW'(1), CW'(0));
        send_vector(CW'(2), CW'(-3), CW'(1));
        send_vector(CW'(-5), CW'(7), CW'(-1));
        send_vector(CW'(32'hAAAA_AAAA), CW'(32'h5555_5555), CW'(32'hFFFF_0000));
    endtask

    task automatic test_pause_drain();
        for (int i = 0; i < 20; i++)
            send_vector(rand_comp(), rand_comp(), rand_comp());
        // hold the sender until the pipe is empty
        wait_drained();
        for (int i = 0; i < 20; i++)
            send_vector(rand_comp(), rand_comp(), rand_comp());
    endtask

    task automatic test_random();
        for (int i = 0; i < 1560; i++)
            send_vector(rand_comp(), rand_comp(), rand_comp());
    endtask

    initial
    begin
        error_count   = 0;
        cycle_count   = 0;
        stall_rx      = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_extremes();
        test_pause_drain();
        test_random();

        wait_drained();
        repeat (LATENCY + 10) @(posedge clk);
        if (error_count == 0)
            $display("vector3_normalize: match");
        else
            $display("vector3_normalize: mismatch");
        $finish;
    end

endmodule
